>>> rtl/gld_pkg.sv
// shared types, constants and tables of the gamma lut dither mapper
`default_nettype none

package gld_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LEVEL_W     = 8;
	localparam int FRAC_W      = 3;
	localparam int ENTRY_W     = LEVEL_W + FRAC_W;

	// configuration register indexes
	localparam logic [1:0] CFG_GAMMA      = 2'd0;
	localparam logic [1:0] CFG_BRIGHTNESS = 2'd1;
	localparam logic [1:0] CFG_OVERSAMPLE = 2'd2;

	// fixed-point constants of the table build
	localparam logic [15:0] Y_INIT          = 16'd65280;
	localparam logic [31:0] MUL_ROUND       = 32'd32768;
	localparam logic [15:0] FULL_SCALE_BASE = 16'd255;
	localparam logic [14:0] DIV10_RECIP     = 15'd205;
	localparam int          DIV10_SHIFT     = 11;

	// command codes
	localparam logic CMD_REBUILD = 1'b0;
	localparam logic CMD_MAP     = 1'b1;

	typedef struct packed {
		logic                 en;
		logic [ADDR_W-1:0]    addr;
		logic [ENTRY_W-1:0]   data;
	} gld_wr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gld_bld_sts_t;

	// dither phase mask for a given oversample depth
	function automatic logic [FRAC_W-1:0] phase_mask_of(input logic [1:0] shift);
		logic [FRAC_W-1:0] m;
		unique case (shift)
			2'd0:    m = 3'h0;
			2'd1:    m = 3'h1;
			2'd2:    m = 3'h3;
			default: m = 3'h7;
		endcase
		return m;
	endfunction

	// tenth-root factors, 16-bit fraction
	localparam logic [15:0] TENTH_ROOT [0:TABLE_DEPTH-1] = '{
		16'd0, 16'd37654, 16'd40357, 16'd42027, 16'd43253, 16'd44229, 16'd45043, 16'd45743,
		16'd46358, 16'd46907, 16'd47404, 16'd47858, 16'd48276, 16'd48664, 16'd49026, 16'd49366,
		16'd49685, 16'd49987, 16'd50274, 16'd50546, 16'd50806, 16'd51055, 16'd51293, 16'd51521,
		16'd51741, 16'd51953, 16'd52157, 16'd52354, 16'd52545, 16'd52730, 16'd52909, 16'd53082,
		16'd53251, 16'd53415, 16'd53575, 16'd53731, 16'd53882, 16'd54030, 16'd54174, 16'd54315,
		16'd54453, 16'd54588, 16'd54719, 16'd54848, 16'd54974, 16'd55098, 16'd55219, 16'd55338,
		16'd55455, 16'd55569, 16'd55682, 16'd55792, 16'd55901, 16'd56007, 16'd56112, 16'd56215,
		16'd56316, 16'd56416, 16'd56514, 16'd56611, 16'd56706, 16'd56800, 16'd56892, 16'd56984,
		16'd57073, 16'd57162, 16'd57249, 16'd57335, 16'd57420, 16'd57504, 16'd57587, 16'd57669,
		16'd57750, 16'd57829, 16'd57908, 16'd57986, 16'd58063, 16'd58139, 16'd58214, 16'd58288,
		16'd58361, 16'd58434, 16'd58506, 16'd58576, 16'd58647, 16'd58716, 16'd58785, 16'd58853,
		16'd58920, 16'd58987, 16'd59053, 16'd59118, 16'd59183, 16'd59247, 16'd59310, 16'd59373,
		16'd59435, 16'd59497, 16'd59558, 16'd59618, 16'd59678, 16'd59738, 16'd59796, 16'd59855,
		16'd59913, 16'd59970, 16'd60027, 16'd60083, 16'd60139, 16'd60195, 16'd60250, 16'd60304,
		16'd60358, 16'd60412, 16'd60465, 16'd60518, 16'd60571, 16'd60623, 16'd60674, 16'd60725,
		16'd60776, 16'd60827, 16'd60877, 16'd60927, 16'd60976, 16'd61025, 16'd61073, 16'd61122,
		16'd61170, 16'd61217, 16'd61265, 16'd61312, 16'd61358, 16'd61405, 16'd61451, 16'd61496,
		16'd61542, 16'd61587, 16'd61632, 16'd61676, 16'd61720, 16'd61764, 16'd61808, 16'd61851,
		16'd61894, 16'd61937, 16'd61980, 16'd62022, 16'd62064, 16'd62106, 16'd62148, 16'd62189,
		16'd62230, 16'd62271, 16'd62311, 16'd62352, 16'd62392, 16'd62432, 16'd62471, 16'd62511,
		16'd62550, 16'd62589, 16'd62628, 16'd62666, 16'd62705, 16'd62743, 16'd62781, 16'd62818,
		16'd62856, 16'd62893, 16'd62930, 16'd62967, 16'd63004, 16'd63041, 16'd63077, 16'd63113,
		16'd63149, 16'd63185, 16'd63220, 16'd63256, 16'd63291, 16'd63326, 16'd63361, 16'd63396,
		16'd63430, 16'd63465, 16'd63499, 16'd63533, 16'd63567, 16'd63601, 16'd63634, 16'd63668,
		16'd63701, 16'd63734, 16'd63767, 16'd63800, 16'd63832, 16'd63865, 16'd63897, 16'd63929,
		16'd63962, 16'd63993, 16'd64025, 16'd64057, 16'd64088, 16'd64120, 16'd64151, 16'd64182,
		16'd64213, 16'd64244, 16'd64274, 16'd64305, 16'd64335, 16'd64366, 16'd64396, 16'd64426,
		16'd64456, 16'd64485, 16'd64515, 16'd64545, 16'd64574, 16'd64603, 16'd64633, 16'd64662,
		16'd64691, 16'd64719, 16'd64748, 16'd64777, 16'd64805, 16'd64834, 16'd64862, 16'd64890,
		16'd64918, 16'd64946, 16'd64974, 16'd65001, 16'd65029, 16'd65057, 16'd65084, 16'd65111,
		16'd65138, 16'd65165, 16'd65192, 16'd65219, 16'd65246, 16'd65273, 16'd65299, 16'd65326,
		16'd65352, 16'd65379, 16'd65405, 16'd65431, 16'd65457, 16'd65483, 16'd65509, 16'd65535
	};

endpackage

`default_nettype wire

>>> rtl/gld_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module gld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/gld_builder.sv
// table rebuild sequencer: one rounded high-16 multiply per cycle in the multiply state
`default_nettype none

module gld_builder
	import gld_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [7:0]   gamma_setting,
	input  wire logic [1:0]   oversample_shift,
	output gld_bld_sts_t      sts,
	output gld_wr_t           wr
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_MUL   = 3'b010,
		ST_WRITE = 3'b100
	} bld_state_t;

	bld_state_t        state_q;
	logic [7:0]        x_q;
	logic [15:0]       y_q;
	logic [3:0]        pot_q;
	logic [3:0]        dec_q;
	logic [3:0]        pot_left_q;
	logic [3:0]        dec_left_q;
	logic [1:0]        shift_q;

	logic [6:0]        half;
	logic [14:0]       half_recip;
	logic [3:0]        pot;
	logic [3:0]        dec;
	logic [15:0]       mul_b;
	logic [31:0]       prod;
	logic [31:0]       prod_rnd;
	logic [FRAC_W-1:0] mask;

	// pot = half / 10 by reciprocal, exact for half below 128
	assign half       = gamma_setting[7:1];
	assign half_recip = 15'(half) * DIV10_RECIP;
	assign pot        = half_recip[14:DIV10_SHIFT];
	assign dec        = 4'(half - 7'(7'(pot) * 7'd10));

	always_comb begin
		priority if (pot_left_q != 4'd0) begin
			mul_b = {x_q, x_q};
		end else if (dec_left_q != 4'd0) begin
			mul_b = TENTH_ROOT[x_q];
		end else begin
			mul_b = FULL_SCALE_BASE << shift_q;
		end
	end

	assign prod     = 32'(y_q) * 32'(mul_b);
	assign prod_rnd = prod + MUL_ROUND;
	assign mask     = phase_mask_of(shift_q);

	assign wr.en   = (state_q == ST_WRITE);
	assign wr.addr = x_q;
	assign wr.data = {8'(y_q >> shift_q), y_q[FRAC_W-1:0] & mask};

	assign sts.busy = (state_q != ST_IDLE);
	assign sts.done = (state_q == ST_WRITE) && (x_q == 8'hFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			x_q        <= 8'd1;
			y_q        <= Y_INIT;
			pot_q      <= 4'd0;
			dec_q      <= 4'd0;
			pot_left_q <= 4'd0;
			dec_left_q <= 4'd0;
			shift_q    <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q    <= ST_MUL;
						x_q        <= 8'd1;
						y_q        <= Y_INIT;
						pot_q      <= pot;
						dec_q      <= dec;
						pot_left_q <= pot;
						dec_left_q <= dec;
						shift_q    <= oversample_shift;
					end
				end
				ST_MUL: begin
					y_q <= prod_rnd[31:16];
					priority if (pot_left_q != 4'd0) begin
						pot_left_q <= pot_left_q - 4'd1;
					end else if (dec_left_q != 4'd0) begin
						dec_left_q <= dec_left_q - 4'd1;
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (x_q == 8'hFF) begin
						state_q <= ST_IDLE;
					end else begin
						state_q    <= ST_MUL;
						x_q        <= x_q + 8'd1;
						y_q        <= Y_INIT;
						pot_left_q <= pot_q;
						dec_left_q <= dec_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/gamma_lut_dither_mapper.sv
// top level of the gamma lut dither mapper: config, map path and table memory
`default_nettype none

// gamma lut dither mapper
// - command channel: a beat is taken at a rising edge with start high and busy
//   low; cmd, pixel_value and end_of_frame form the beat
// - result channel: out_strobe marks one cycle holding out_value and
//   rebuild_done; the receiver cannot stall, so every result shows once
// - config port: cfg_wr_en writes cfg_wdata into register cfg_addr
//   (0 gamma, 1 brightness, 2 oversample); other indexes are dropped
// - map: one beat per cycle while busy is low; the result is registered in
//   stage 1 and the output stage; the byte is scaled by brightness, looked
//   up in the level/fraction memory and dithered (passed on at gamma 0)
// - rebuild: for x = 1..255 the sequencer's single 16x16 multiplier takes
//   pot factors x*257, dec tenth roots and the full scale, then the entry
//   is written; busy is high meanwhile and the result follows the last write
// - reset: config goes to gamma 0, brightness 255, oversample 0; the tables
//   read as zero until the first rebuild completes, the dither phase is zero
`default_nettype none

module gamma_lut_dither_mapper
	import gld_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic         cmd,
	input  wire logic [7:0]   pixel_value,
	input  wire logic         end_of_frame,
	output logic              out_strobe,
	output logic [7:0]        out_value,
	output logic              rebuild_done,
	input  wire logic         cfg_wr_en,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [7:0]   cfg_wdata
);

	// configuration registers
	logic [7:0]        gamma_q;
	logic [7:0]        brightness_q;
	logic [1:0]        oversample_q;

	// dither state and table status
	logic [FRAC_W-1:0] dither_phase_q;
	logic [FRAC_W-1:0] phase_mask_q;
	logic              built_q;

	// map pipeline, stage 1 waits on the memory read
	logic              map_s1;
	logic              eof_s1;
	logic              bypass_s1;
	logic              idx_zero_s1;
	logic [7:0]        pix_s1;

	logic              strobe_q;
	logic [7:0]        out_value_q;
	logic              rebuild_done_q;

	logic              accept;
	logic              map_go;
	logic              rebuild_go;
	logic [15:0]       scaled;
	logic [ADDR_W-1:0] idx;
	logic [ENTRY_W-1:0] rd_entry;
	logic              entry_valid;
	logic [LEVEL_W-1:0] level;
	logic [FRAC_W-1:0] frac;
	logic [7:0]        map_result;

	gld_bld_sts_t      bld_sts;
	gld_wr_t           bld_wr;

	assign busy       = bld_sts.busy;
	assign accept     = start && !bld_sts.busy;
	assign map_go     = accept && (cmd == CMD_MAP);
	assign rebuild_go = accept && (cmd == CMD_REBUILD);

	// brightness scaling feeds the memory address directly
	assign scaled = 16'(pixel_value) * 16'(brightness_q);
	assign idx    = scaled[15:8];

	gld_builder u_builder (
		.clk              (clk),
		.arst_n           (arst_n),
		.go               (rebuild_go),
		.gamma_setting    (gamma_q),
		.oversample_shift (oversample_q),
		.sts              (bld_sts),
		.wr               (bld_wr)
	);

	// level in the upper bits, fraction in the lower bits
	gld_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (bld_wr.en),
		.wr_addr (bld_wr.addr),
		.wr_data (bld_wr.data),
		.rd_addr (idx),
		.rd_data (rd_entry)
	);

	// entry 0 is never written, and nothing is before the first rebuild
	assign entry_valid = built_q && !idx_zero_s1;
	assign level       = entry_valid ? rd_entry[ENTRY_W-1:FRAC_W] : '0;
	assign frac        = entry_valid ? rd_entry[FRAC_W-1:0] : '0;

	always_comb begin
		if (bypass_s1) begin
			map_result = pix_s1;
		end else begin
			map_result = level + 8'(frac > dither_phase_q);
		end
	end

	// config and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q        <= 8'd0;
			brightness_q   <= 8'd255;
			oversample_q   <= 2'd0;
			dither_phase_q <= '0;
			phase_mask_q   <= '0;
			built_q        <= 1'b0;
			map_s1         <= 1'b0;
			strobe_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					CFG_GAMMA:      gamma_q      <= cfg_wdata;
					CFG_BRIGHTNESS: brightness_q <= cfg_wdata;
					CFG_OVERSAMPLE: oversample_q <= cfg_wdata[1:0];
					default: begin
					end
				endcase
			end
			// map in stage 1 sees the old mask even if a rebuild starts now
			if (map_s1 && eof_s1) begin
				dither_phase_q <= (dither_phase_q + 3'd1) & phase_mask_q;
			end
			if (rebuild_go) begin
				phase_mask_q <= phase_mask_of(oversample_q);
			end
			if (bld_sts.done) begin
				built_q <= 1'b1;
			end
			map_s1   <= map_go;
			strobe_q <= map_s1 || bld_sts.done;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		eof_s1         <= end_of_frame;
		bypass_s1      <= (gamma_q == 8'd0);
		idx_zero_s1    <= (idx == '0);
		pix_s1         <= pixel_value;
		out_value_q    <= map_s1 ? map_result : 8'd0;
		rebuild_done_q <= bld_sts.done;
	end

	assign out_strobe   = strobe_q;
	assign out_value    = out_value_q;
	assign rebuild_done = rebuild_done_q;

`ifndef NO_ASSERTIONS
	// a rebuild beat makes the block busy on the next cycle
	a_rebuild_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_REBUILD)) |=> busy)
		else $error("rebuild beat did not raise busy");

	// a map beat yields a map result through stage 1 and the output registers
	a_map_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_MAP)) |-> ##2 (out_strobe && !rebuild_done))
		else $error("map result missing two cycles after beat");

	// the rebuild result arrives only once the sequencer has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_strobe && rebuild_done) |-> (!busy && built_q))
		else $error("rebuild result while sequencer still busy");

	// the table memory is written only during a rebuild
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bld_wr.en |-> (busy && !map_go))
		else $error("table write outside a rebuild");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking bench for the gamma lut dither mapper: curve predictor, scoreboard and stimulus
`default_nettype none

module tb;
	import gld_pkg::*;

	// run guard, far above the slowest legal run, with every rebuild at gamma 255
	localparam int          CYCLE_LIMIT = 1_500_000;
	localparam int          SEGMENTS    = 10;
	localparam int          SEG_BEATS   = 95;
	localparam int          GAP_CAP     = 64;
	localparam logic [1:0]  CFG_SPARE   = 2'd3;       // unmapped register index, must be dropped
	localparam logic [15:0] CURVE_START = 16'd65280;  // fixed-point start of every curve entry
	localparam logic [15:0] STEP_257    = 16'd257;    // byte to 16-bit scale factor

	// tenth-root factors of x, 16-bit fraction; kept apart from the design's own copy
	localparam logic [15:0] ROOT10 [0:255] = '{
		16'd0,     16'd37654, 16'd40357, 16'd42027, 16'd43253, 16'd44229, 16'd45043, 16'd45743,
		16'd46358, 16'd46907, 16'd47404, 16'd47858, 16'd48276, 16'd48664, 16'd49026, 16'd49366,
		16'd49685, 16'd49987, 16'd50274, 16'd50546, 16'd50806, 16'd51055, 16'd51293, 16'd51521,
		16'd51741, 16'd51953, 16'd52157, 16'd52354, 16'd52545, 16'd52730, 16'd52909, 16'd53082,
		16'd53251, 16'd53415, 16'd53575, 16'd53731, 16'd53882, 16'd54030, 16'd54174, 16'd54315,
		16'd54453, 16'd54588, 16'd54719, 16'd54848, 16'd54974, 16'd55098, 16'd55219, 16'd55338,
		16'd55455, 16'd55569, 16'd55682, 16'd55792, 16'd55901, 16'd56007, 16'd56112, 16'd56215,
		16'd56316, 16'd56416, 16'd56514, 16'd56611, 16'd56706, 16'd56800, 16'd56892, 16'd56984,
		16'd57073, 16'd57162, 16'd57249, 16'd57335, 16'd57420, 16'd57504, 16'd57587, 16'd57669,
		16'd57750, 16'd57829, 16'd57908, 16'd57986, 16'd58063, 16'd58139, 16'd58214, 16'd58288,
		16'd58361, 16'd58434, 16'd58506, 16'd58576, 16'd58647, 16'd58716, 16'd58785, 16'd58853,
		16'd58920, 16'd58987, 16'd59053, 16'd59118, 16'd59183, 16'd59247, 16'd59310, 16'd59373,
		16'd59435, 16'd59497, 16'd59558, 16'd59618, 16'd59678, 16'd59738, 16'd59796, 16'd59855,
		16'd59913, 16'd59970, 16'd60027, 16'd60083, 16'd60139, 16'd60195, 16'd60250, 16'd60304,
		16'd60358, 16'd60412, 16'd60465, 16'd60518, 16'd60571, 16'd60623, 16'd60674, 16'd60725,
		16'd60776, 16'd60827, 16'd60877, 16'd60927, 16'd60976, 16'd61025, 16'd61073, 16'd61122,
		16'd61170, 16'd61217, 16'd61265, 16'd61312, 16'd61358, 16'd61405, 16'd61451, 16'd61496,
		16'd61542, 16'd61587, 16'd61632, 16'd61676, 16'd61720, 16'd61764, 16'd61808, 16'd61851,
		16'd61894, 16'd61937, 16'd61980, 16'd62022, 16'd62064, 16'd62106, 16'd62148, 16'd62189,
		16'd62230, 16'd62271, 16'd62311, 16'd62352, 16'd62392, 16'd62432, 16'd62471, 16'd62511,
		16'd62550, 16'd62589, 16'd62628, 16'd62666, 16'd62705, 16'd62743, 16'd62781, 16'd62818,
		16'd62856, 16'd62893, 16'd62930, 16'd62967, 16'd63004, 16'd63041, 16'd63077, 16'd63113,
		16'd63149, 16'd63185, 16'd63220, 16'd63256, 16'd63291, 16'd63326, 16'd63361, 16'd63396,
		16'd63430, 16'd63465, 16'd63499, 16'd63533, 16'd63567, 16'd63601, 16'd63634, 16'd63668,
		16'd63701, 16'd63734, 16'd63767, 16'd63800, 16'd63832, 16'd63865, 16'd63897, 16'd63929,
		16'd63962, 16'd63993, 16'd64025, 16'd64057, 16'd64088, 16'd64120, 16'd64151, 16'd64182,
		16'd64213, 16'd64244, 16'd64274, 16'd64305, 16'd64335, 16'd64366, 16'd64396, 16'd64426,
		16'd64456, 16'd64485, 16'd64515, 16'd64545, 16'd64574, 16'd64603, 16'd64633, 16'd64662,
		16'd64691, 16'd64719, 16'd64748, 16'd64777, 16'd64805, 16'd64834, 16'd64862, 16'd64890,
		16'd64918, 16'd64946, 16'd64974, 16'd65001, 16'd65029, 16'd65057, 16'd65084, 16'd65111,
		16'd65138, 16'd65165, 16'd65192, 16'd65219, 16'd65246, 16'd65273, 16'd65299, 16'd65326,
		16'd65352, 16'd65379, 16'd65405, 16'd65431, 16'd65457, 16'd65483, 16'd65509, 16'd65535
	};

	// one result beat as the design shows it
	typedef struct {
		logic [7:0] value;
		logic       done;
	} led_result_t;

	// in-order store of awaited results; one result per command beat
	class byte_checker;
		led_result_t awaited[$];
		int          faults;

		function new();
			faults = 0;
		endfunction

		function void note(led_result_t r);
			awaited.push_back(r);
		endfunction

		task report(string msg);
			$display("tb: mismatch: %s", msg);
			faults++;
		endtask

		task check(logic [7:0] got_value, logic got_done);
			led_result_t e;
			if (awaited.size() == 0) begin
				report($sformatf("stray result value %0d done %0b", got_value, got_done));
				return;
			end
			e = awaited.pop_front();
			if (got_value !== e.value)
				report($sformatf("out_value %0d, predicted %0d", got_value, e.value));
			if (got_done !== e.done)
				report($sformatf("rebuild_done %0b, predicted %0b", got_done, e.done));
		endtask
	endclass

	// design ports; every input known from time zero
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       start        = 1'b0;
	logic       cmd          = 1'b0;
	logic [7:0] pixel_value  = 8'd0;
	logic       end_of_frame = 1'b0;
	logic       cfg_wr_en    = 1'b0;
	logic [1:0] cfg_addr     = 2'd0;
	logic [7:0] cfg_wdata    = 8'd0;
	logic       busy;
	logic       out_strobe;
	logic [7:0] out_value;
	logic       rebuild_done;

	// predictor state: curve tables, dither phase and the register copies
	logic [7:0] lvl_mem  [0:255];
	logic [2:0] frac_mem [0:255];
	logic [2:0] phase_now  = 3'd0;
	logic [2:0] phase_lim  = 3'd0;
	logic [7:0] gamma_reg  = 8'd0;
	logic [7:0] bright_reg = 8'd255;
	logic [1:0] os_reg     = 2'd0;

	int          idle_pct = 0;   // chance in a hundred that the sender sits out a cycle
	int unsigned cycles   = 0;
	byte_checker board;

	gamma_lut_dither_mapper dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.pixel_value  (pixel_value),
		.end_of_frame (end_of_frame),
		.out_strobe   (out_strobe),
		.out_value    (out_value),
		.rebuild_done (rebuild_done),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// tables read as zero until the first rebuild
	initial begin
		for (int i = 0; i < 256; i++) begin
			lvl_mem[i]  = 8'd0;
			frac_mem[i] = 3'd0;
		end
	end

	// rounded high half of a 16x16 product
	function automatic logic [15:0] mul_round(logic [15:0] a, logic [15:0] b);
		logic [31:0] p;
		p = {16'd0, a} * {16'd0, b} + 32'd32768;
		return p[31:16];
	endfunction

	// gamma curve: pot whole powers of x*257, dec tenth roots, then scaled to 255 << depth
	function automatic void rebuild_curve();
		logic [7:0]  half;
		logic [15:0] y;
		logic [15:0] scale;
		int          pot;
		int          dec;
		int          sh;
		half      = gamma_reg >> 1;
		pot       = half / 10;
		dec       = half % 10;
		sh        = os_reg;
		phase_lim = 3'((1 << sh) - 1);
		scale     = 16'(255 << sh);
		// entry 0 is never touched, so black stays black
		for (int x = 1; x < 256; x++) begin
			y = CURVE_START;
			repeat (pot) y = mul_round(y, 16'(x) * STEP_257);
			repeat (dec) y = mul_round(y, ROOT10[x]);
			y           = mul_round(y, scale);
			lvl_mem[x]  = 8'(y >> sh);
			frac_mem[x] = 3'(y) & phase_lim;
		end
	endfunction

	// predicted result of one accepted command beat, state moved on as the design does
	function automatic led_result_t apply_beat(logic c, logic [7:0] pix, logic eof);
		led_result_t r;
		logic [15:0] prod;
		logic [7:0]  idx;
		if (c == CMD_REBUILD) begin
			// payload ignored, phase left alone
			rebuild_curve();
			r.value = 8'd0;
			r.done  = 1'b1;
			return r;
		end
		r.done = 1'b0;
		if (gamma_reg != 8'd0) begin
			prod    = {8'd0, pix} * {8'd0, bright_reg};
			idx     = prod[15:8];
			r.value = lvl_mem[idx] + ((frac_mem[idx] > phase_now) ? 8'd1 : 8'd0);
		end else begin
			// bypass: colour byte passes untouched
			r.value = pix;
		end
		// frame end steps the phase, bypass or not
		if (eof)
			phase_now = (phase_now + 3'd1) & phase_lim;
		return r;
	endfunction

	// one command beat; waits for the handshake, then maybe sits out a random gap
	task automatic send_beat(logic c, logic [7:0] pix, logic eof);
		int gap;
		start        <= 1'b1;
		cmd          <= c;
		pixel_value  <= pix;
		end_of_frame <= eof;
		do @(posedge clk); while (busy);
		board.note(apply_beat(c, pix, eof));
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every awaited result is in and the design is quiet
	task automatic drain();
		start <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write, only ever with the design idle
	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_GAMMA:      gamma_reg  = val;
			CFG_BRIGHTNESS: bright_reg = val;
			CFG_OVERSAMPLE: os_reg     = val[1:0];
			default: ;
		endcase
	endtask

	// mostly random colour bytes, with black and full white now and then
	function automatic logic [7:0] pick_pixel();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	task automatic directed_beats();
		// bypass straight after reset; frame end with a zero mask keeps phase at 0
		send_beat(CMD_MAP, 8'h00, 1'b0);
		send_beat(CMD_MAP, 8'hFF, 1'b1);
		send_beat(CMD_MAP, 8'hA5, 1'b1);
		// gamma on but no rebuild yet: tables still empty
		write_reg(CFG_GAMMA, 8'd44);
		send_beat(CMD_MAP, 8'hFF, 1'b0);
		send_beat(CMD_MAP, 8'h5A, 1'b1);
		// deepest dither, upper data bits must be dropped; rebuild ignores its payload
		write_reg(CFG_OVERSAMPLE, 8'hFF);
		send_beat(CMD_REBUILD, 8'hFF, 1'b1);
		send_beat(CMD_MAP, 8'hFF, 1'b1);
		send_beat(CMD_MAP, 8'h01, 1'b1);
		send_beat(CMD_MAP, 8'h80, 1'b1);
		send_beat(CMD_MAP, 8'h40, 1'b1);
		send_beat(CMD_MAP, 8'hC8, 1'b1);
		// write to an unmapped index changes nothing
		write_reg(CFG_SPARE, 8'hFF);
		send_beat(CMD_MAP, 8'hC8, 1'b0);
		// bypass still steps the phase; gamma back on without a rebuild keeps the old curve
		write_reg(CFG_GAMMA, 8'd0);
		send_beat(CMD_MAP, 8'h77, 1'b1);
		write_reg(CFG_GAMMA, 8'd100);
		send_beat(CMD_MAP, 8'hB4, 1'b0);
		// brightness acts at once: zero forces index 0
		write_reg(CFG_BRIGHTNESS, 8'd0);
		send_beat(CMD_MAP, 8'hFF, 1'b0);
		write_reg(CFG_BRIGHTNESS, 8'd128);
		send_beat(CMD_MAP, 8'hFF, 1'b1);
		// shrink the mask while the phase sits above it, then wrap it
		write_reg(CFG_OVERSAMPLE, 8'd0);
		send_beat(CMD_REBUILD, 8'h00, 1'b0);
		send_beat(CMD_MAP, 8'hC8, 1'b1);
		// curve extremes: steepest gamma, then the flattest
		write_reg(CFG_GAMMA, 8'd255);
		write_reg(CFG_BRIGHTNESS, 8'd255);
		send_beat(CMD_REBUILD, 8'h00, 1'b0);
		send_beat(CMD_MAP, 8'hFF, 1'b0);
		send_beat(CMD_MAP, 8'h01, 1'b0);
		write_reg(CFG_GAMMA, 8'd1);
		send_beat(CMD_REBUILD, 8'h00, 1'b0);
		send_beat(CMD_MAP, 8'hFF, 1'b0);
	endtask

	// segments of one setting each, maybe retuned midway: rebuild, then a stream of frames with rare rebuilds
	task automatic random_segments();
		logic [7:0] g;
		logic [7:0] b;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0:       g = 8'd255;
				1:       g = 8'd0;
				2:       g = 8'd2;
				3:       g = 8'd44;
				4:       g = 8'd254;
				default: g = 8'($urandom_range(255));
			endcase
			case (seg)
				2:       b = 8'd0;
				0, 3:    b = 8'd255;
				default: b = 8'($urandom_range(255));
			endcase
			write_reg(CFG_GAMMA, g);
			write_reg(CFG_BRIGHTNESS, b);
			write_reg(CFG_OVERSAMPLE, {6'($urandom_range(63)), 2'(seg % 4)});
			if ($urandom_range(1))
				write_reg(CFG_SPARE, 8'($urandom_range(255)));
			// no idling, sender mostly idle, light idling
			case (seg % 4)
				1, 3:    idle_pct = 88;
				2:       idle_pct = 16;
				default: idle_pct = 0;
			endcase
			send_beat(CMD_REBUILD, 8'($urandom_range(255)), 1'($urandom_range(1)));
			for (int i = 0; i < SEG_BEATS; i++) begin
				// mid-stream retune: gamma and brightness bite now, depth only on rebuild
				if (i == SEG_BEATS / 2 && $urandom_range(1)) begin
					write_reg(CFG_BRIGHTNESS, 8'($urandom_range(255)));
					if ($urandom_range(2) == 0)
						write_reg(CFG_GAMMA, 8'($urandom_range(255)));
					if ($urandom_range(2) == 0)
						write_reg(CFG_OVERSAMPLE, 8'($urandom_range(255)));
				end
				if ($urandom_range(79) == 0)
					send_beat(CMD_REBUILD, 8'($urandom_range(255)), 1'($urandom_range(1)));
				else
					send_beat(CMD_MAP, pick_pixel(), $urandom_range(5) == 0);
			end
		end
	endtask

	// results cannot be held off; take each one at the edge that closes its cycle
	always @(posedge clk) begin
		if (arst_n && out_strobe)
			board.check(out_value, rebuild_done);
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_beats();
		random_segments();
		// everything in, then a short tail for anything late
		drain();
		repeat (8) @(posedge clk);
		if (board.faults == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
